// ===== rtl/m3i_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// m3i_pkg: shared types and constants for the 3x3 matrix inverse
// Field widths, internal datapath widths, cofactor index table, job and
// payload structs used by the front end, the job queue and the divider back end.
// ----------------------------------------------------------------------------
package m3i_pkg;

  localparam int DATA_W      = 32;            // width of every matrix entry
  localparam int FRAC_DEF    = 16;            // default fraction bits
  localparam int MUL_CHUNK   = 24;            // multiplier operand slice
  localparam int NUM_ENT     = 9;
  localparam int COF_W       = 2 * DATA_W + 1;
  localparam int DET_W       = 3 * DATA_W + 3;
  localparam int REM_W       = DET_W + DATA_W;
  localparam int QUEUE_DEPTH = 4;

  localparam logic [DATA_W-1:0] SAT_MAX = {1'b0, {(DATA_W-1){1'b1}}};
  localparam logic [DATA_W-1:0] SAT_MIN = {1'b1, {(DATA_W-1){1'b0}}};

  // adjugate entry i = m[p]*m[q] - m[r]*m[s], entries numbered row by row
  localparam int MINOR_IDX [NUM_ENT][4] = '{
    '{4, 8, 7, 5}, '{7, 2, 1, 8}, '{1, 5, 4, 2},
    '{5, 6, 8, 3}, '{8, 0, 2, 6}, '{2, 3, 5, 0},
    '{3, 7, 6, 4}, '{6, 1, 0, 7}, '{0, 4, 3, 1}
  };

  typedef struct packed {
    logic signed [DATA_W-1:0] a11;
    logic signed [DATA_W-1:0] a12;
    logic signed [DATA_W-1:0] a13;
    logic signed [DATA_W-1:0] a21;
    logic signed [DATA_W-1:0] a22;
    logic signed [DATA_W-1:0] a23;
    logic signed [DATA_W-1:0] a31;
    logic signed [DATA_W-1:0] a32;
    logic signed [DATA_W-1:0] a33;
  } m3i_in_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] inv11;
    logic signed [DATA_W-1:0] inv12;
    logic signed [DATA_W-1:0] inv13;
    logic signed [DATA_W-1:0] inv21;
    logic signed [DATA_W-1:0] inv22;
    logic signed [DATA_W-1:0] inv23;
    logic signed [DATA_W-1:0] inv31;
    logic signed [DATA_W-1:0] inv32;
    logic signed [DATA_W-1:0] inv33;
    logic signed [DATA_W-1:0] det_value;
    logic                     invertible;
    logic                     saturated;
  } m3i_out_t;

  // one classified matrix waiting for division
  typedef struct packed {
    logic                            singular;
    logic [DET_W-1:0]                det;
    logic [NUM_ENT-1:0][COF_W-1:0]   cof;
  } m3i_job_t;

  // per-item side information carried down the divider pipeline
  typedef struct packed {
    logic               singular;
    logic               det_clip;
    logic [DATA_W-1:0]  det_v;
    logic [NUM_ENT-1:0] neg;
    logic [NUM_ENT-1:0] ovf;
  } m3i_side_t;

endpackage

// ===== rtl/m3i_mul.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// m3i_mul: two-stage signed multiplier
// Slices operand b, registers the slice products, then sums them into the
// registered full-width product.
// ----------------------------------------------------------------------------
module m3i_mul import m3i_pkg::*; #(
  parameter int AW = DATA_W,
  parameter int BW = DATA_W
) (
  input  logic                    clk,
  input  logic                    en,
  input  logic signed [AW-1:0]    a,
  input  logic signed [BW-1:0]    b,
  output logic signed [AW+BW-1:0] p
);

  localparam int NCH  = (BW + MUL_CHUNK - 1) / MUL_CHUNK;
  localparam int BX_W = NCH * MUL_CHUNK;
  localparam int PP_W = AW + MUL_CHUNK + 1;
  localparam int P_W  = AW + BW;

  logic signed [BX_W-1:0] b_ext;
  logic signed [PP_W-1:0] pp_r [NCH];
  logic signed [P_W-1:0]  sum_nxt;
  logic signed [P_W-1:0]  p_r;

  assign b_ext = BX_W'(b);

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < NCH; k++) begin
        // top slice carries the sign, lower slices are unsigned
        if (k == NCH - 1) begin
          pp_r[k] <= a * $signed(b_ext[k*MUL_CHUNK +: MUL_CHUNK]);
        end else begin
          pp_r[k] <= a * $signed({1'b0, b_ext[k*MUL_CHUNK +: MUL_CHUNK]});
        end
      end
    end
  end

  always_comb begin
    sum_nxt = '0;
    for (int k = 0; k < NCH; k++) begin
      sum_nxt = sum_nxt + (P_W'(pp_r[k]) <<< (k * MUL_CHUNK));
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p_r <= sum_nxt;
    end
  end

  assign p = p_r;

endmodule

// ===== rtl/m3i_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// m3i_front: cofactor and determinant pipeline
// Accepts matrices, forms the nine exact cofactors and the exact determinant,
// flags singular matrices and pushes one job per matrix into the queue.
// ----------------------------------------------------------------------------
module m3i_front import m3i_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  input  m3i_in_t  in_data,
  input  logic     q_full,
  output logic     q_push,
  output m3i_job_t q_wdata
);

  localparam int PRD_W = 2 * DATA_W;
  localparam int DP_W  = DATA_W + COF_W;
  localparam int NSTG  = 7;

  logic                     en;
  logic [NSTG-1:0]          v_r;
  logic signed [DATA_W-1:0] m_in [NUM_ENT];
  logic signed [DATA_W-1:0] m_r [NUM_ENT];
  logic signed [DATA_W-1:0] row_r [3][3];
  logic signed [PRD_W-1:0]  prd [2*NUM_ENT];
  logic signed [COF_W-1:0]  cof_r [4][NUM_ENT];
  logic signed [DP_W-1:0]   dprd [3];
  logic signed [DET_W-1:0]  det_r;

  // hold the whole pipeline only when a finished job cannot enter the queue
  assign en       = !(v_r[NSTG-1] && q_full);
  assign in_stall = !en;
  assign q_push   = v_r[NSTG-1] && !q_full;

  assign m_in[0] = in_data.a11;
  assign m_in[1] = in_data.a12;
  assign m_in[2] = in_data.a13;
  assign m_in[3] = in_data.a21;
  assign m_in[4] = in_data.a22;
  assign m_in[5] = in_data.a23;
  assign m_in[6] = in_data.a31;
  assign m_in[7] = in_data.a32;
  assign m_in[8] = in_data.a33;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[NSTG-2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m_r <= m_in;
      for (int i = 0; i < 3; i++) begin
        row_r[0][i] <= m_r[i];
        row_r[1][i] <= row_r[0][i];
        row_r[2][i] <= row_r[1][i];
      end
      for (int i = 0; i < NUM_ENT; i++) begin
        cof_r[0][i] <= COF_W'(prd[2*i]) - COF_W'(prd[2*i+1]);
        cof_r[1][i] <= cof_r[0][i];
        cof_r[2][i] <= cof_r[1][i];
        cof_r[3][i] <= cof_r[2][i];
      end
      det_r <= DET_W'(dprd[0]) + DET_W'(dprd[1]) + DET_W'(dprd[2]);
    end
  end

  for (genvar g = 0; g < NUM_ENT; g++) begin : g_cof
    m3i_mul #(.AW(DATA_W), .BW(DATA_W)) u_mul_a (
      .clk (clk),
      .en  (en),
      .a   (m_r[MINOR_IDX[g][0]]),
      .b   (m_r[MINOR_IDX[g][1]]),
      .p   (prd[2*g])
    );
    m3i_mul #(.AW(DATA_W), .BW(DATA_W)) u_mul_b (
      .clk (clk),
      .en  (en),
      .a   (m_r[MINOR_IDX[g][2]]),
      .b   (m_r[MINOR_IDX[g][3]]),
      .p   (prd[2*g+1])
    );
  end

  // expand along row 1: a11*C11 + a12*C12 + a13*C13 (adjugate column 1)
  for (genvar g = 0; g < 3; g++) begin : g_det
    m3i_mul #(.AW(DATA_W), .BW(COF_W)) u_mul_d (
      .clk (clk),
      .en  (en),
      .a   (row_r[2][g]),
      .b   (cof_r[0][3*g]),
      .p   (dprd[g])
    );
  end

  always_comb begin
    q_wdata.singular = (det_r == '0);
    q_wdata.det      = det_r;
    for (int i = 0; i < NUM_ENT; i++) begin
      q_wdata.cof[i] = cof_r[3][i];
    end
  end

endmodule

// ===== rtl/m3i_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// m3i_queue: job queue between front end and divider
// Small circular buffer; lets either side stall without stopping the other.
// ----------------------------------------------------------------------------
module m3i_queue import m3i_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     push,
  input  m3i_job_t wdata,
  output logic     full,
  input  logic     pop,
  output m3i_job_t rdata,
  output logic     empty
);

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = PTR_W + 1;

  m3i_job_t         mem_r [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;

  assign full  = (cnt_r == CNT_W'(QUEUE_DEPTH));
  assign empty = (cnt_r == '0);
  assign rdata = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !full)
    else $error("job queue written while full");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> !empty)
    else $error("job queue read while empty");

  a_count_up: assert property (@(posedge clk) disable iff (!rst_n)
    (push && !pop) |=> (cnt_r == $past(cnt_r) + 1'b1))
    else $error("job queue count lost a write");

  a_count_down: assert property (@(posedge clk) disable iff (!rst_n)
    (pop && !push) |=> (cnt_r == $past(cnt_r) - 1'b1))
    else $error("job queue count lost a read");

endmodule

// ===== rtl/m3i_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// m3i_back: pipelined divider and saturation
// Nine restoring-division lanes, one quotient bit per stage, then rounding
// toward zero, saturation and the output register.
// ----------------------------------------------------------------------------
module m3i_back import m3i_pkg::*; #(
  parameter int FRAC_BITS = FRAC_DEF
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     q_empty,
  output logic     q_pop,
  input  m3i_job_t q_rdata,
  output logic     out_valid,
  input  logic     out_stall,
  output m3i_out_t out_data
);

  localparam int NSTEP = DATA_W;
  localparam int NSTG  = NSTEP + 2;
  localparam int LAST  = NSTG - 1;
  localparam logic [DET_W-1:0] DET_HALF = DET_W'(1) << (DATA_W - 1);

  logic                en;
  logic [NSTG-1:0]     v_r;
  logic [REM_W-1:0]    rem_r [NSTG][NUM_ENT];
  logic [DATA_W-1:0]   quo_r [NSTG][NUM_ENT];
  logic [DET_W-1:0]    dmag_r [NSTG];
  m3i_side_t           side_r [NSTG];
  logic [DET_W-1:0]    detmag_r;
  logic                detneg_r;

  logic [COF_W-1:0]    cmag [NUM_ENT];
  logic [DET_W-1:0]    dabs;
  m3i_side_t           side0;
  m3i_side_t           side1;
  logic                det_clip;
  logic [DATA_W-1:0]   det_v;
  logic                step_ge [NSTEP][NUM_ENT];
  logic [REM_W-1:0]    step_rem [NSTEP][NUM_ENT];
  logic [DATA_W-1:0]   inv [NUM_ENT];
  logic                any_clip;
  m3i_out_t            out_nxt;
  m3i_out_t            out_data_r;
  logic                out_valid_r;

  // advance everything whenever the output register can move
  assign en        = !out_valid_r || !out_stall;
  assign q_pop     = en && !q_empty;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // magnitudes and result signs of the fresh job
  always_comb begin
    dabs = q_rdata.det[DET_W-1] ? -q_rdata.det : q_rdata.det;
    side0          = '0;
    side0.singular = q_rdata.singular;
    for (int i = 0; i < NUM_ENT; i++) begin
      cmag[i] = q_rdata.cof[i][COF_W-1] ? -q_rdata.cof[i] : q_rdata.cof[i];
      side0.neg[i] = q_rdata.cof[i][COF_W-1] ^ q_rdata.det[DET_W-1];
    end
  end

  always_comb begin
    if (detneg_r) begin
      det_clip = (detmag_r > DET_HALF);
      det_v    = det_clip ? SAT_MIN : -detmag_r[DATA_W-1:0];
    end else begin
      det_clip = (detmag_r >= DET_HALF);
      det_v    = det_clip ? SAT_MAX : detmag_r[DATA_W-1:0];
    end
  end

  // range check: quotient does not fit the quotient register
  always_comb begin
    side1          = side_r[0];
    side1.det_clip = det_clip;
    side1.det_v    = det_v;
    for (int i = 0; i < NUM_ENT; i++) begin
      side1.ovf[i] = (rem_r[0][i] >= (REM_W'(dmag_r[0]) << DATA_W));
    end
  end

  // one quotient bit per stage, most significant first
  always_comb begin
    logic [REM_W-1:0] dsh;
    for (int k = 0; k < NSTEP; k++) begin
      dsh = REM_W'(dmag_r[k+1]) << (DATA_W - 1 - k);
      for (int i = 0; i < NUM_ENT; i++) begin
        step_ge[k][i]  = (rem_r[k+1][i] >= dsh);
        step_rem[k][i] = step_ge[k][i] ? rem_r[k+1][i] - dsh : rem_r[k+1][i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r         <= '0;
      out_valid_r <= 1'b0;
    end else if (en) begin
      v_r         <= {v_r[NSTG-2:0], q_pop};
      out_valid_r <= v_r[LAST];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      // prepare: numerator magnitude scaled by 2^(2*FRAC_BITS)
      for (int i = 0; i < NUM_ENT; i++) begin
        rem_r[0][i] <= REM_W'(cmag[i]) << (2 * FRAC_BITS);
        quo_r[0][i] <= '0;
      end
      dmag_r[0] <= dabs;
      side_r[0] <= side0;
      detmag_r  <= dabs >> (2 * FRAC_BITS);
      detneg_r  <= q_rdata.det[DET_W-1];

      side_r[1] <= side1;
      for (int i = 0; i < NUM_ENT; i++) begin
        rem_r[1][i] <= rem_r[0][i];
        quo_r[1][i] <= '0;
      end
      dmag_r[1] <= dmag_r[0];

      for (int k = 0; k < NSTEP; k++) begin
        for (int i = 0; i < NUM_ENT; i++) begin
          rem_r[k+2][i] <= step_rem[k][i];
          quo_r[k+2][i] <= {quo_r[k+1][i][DATA_W-2:0], step_ge[k][i]};
        end
        dmag_r[k+2] <= dmag_r[k+1];
        side_r[k+2] <= side_r[k+1];
      end

      out_data_r <= out_nxt;
    end
  end

  always_comb begin
    logic clip;
    logic neg;
    any_clip = side_r[LAST].det_clip;
    for (int i = 0; i < NUM_ENT; i++) begin
      neg  = side_r[LAST].neg[i];
      clip = side_r[LAST].ovf[i] |
             (neg ? (quo_r[LAST][i] > SAT_MIN) : quo_r[LAST][i][DATA_W-1]);
      if (clip) begin
        inv[i] = neg ? SAT_MIN : SAT_MAX;
      end else begin
        inv[i] = neg ? -quo_r[LAST][i] : quo_r[LAST][i];
      end
      any_clip = any_clip | clip;
    end

    out_nxt.inv11      = inv[0];
    out_nxt.inv12      = inv[1];
    out_nxt.inv13      = inv[2];
    out_nxt.inv21      = inv[3];
    out_nxt.inv22      = inv[4];
    out_nxt.inv23      = inv[5];
    out_nxt.inv31      = inv[6];
    out_nxt.inv32      = inv[7];
    out_nxt.inv33      = inv[8];
    out_nxt.det_value  = side_r[LAST].det_v;
    out_nxt.invertible = 1'b1;
    out_nxt.saturated  = any_clip;
    // singular matrix: zero everything
    if (side_r[LAST].singular) begin
      out_nxt = '0;
    end
  end

endmodule

// ===== rtl/matrix3x3_inverse_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// matrix3x3_inverse_top: 3x3 signed fixed-point matrix inverse
// Adjugate over determinant with exact intermediate arithmetic, rounding
// toward zero and saturation of every output entry.
// ----------------------------------------------------------------------------
// Accepts one matrix per clock and delivers one result per clock when
// neither side stalls. A matrix passes through the cofactor and
// determinant pipeline, is registered in the job queue, and then passes
// through the divider pipeline (one quotient bit per stage, 32 bits at the
// default width). A stall on the output freezes only the divider; the
// queue (4 jobs) keeps the input side running until it fills. Singular
// matrices return all zeros with invertible low.
module matrix3x3_inverse_top import m3i_pkg::*; #(
  parameter int FRAC_BITS = FRAC_DEF
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  input  m3i_in_t  in_data,
  output logic     out_valid,
  input  logic     out_stall,
  output m3i_out_t out_data
);

  logic     q_push;
  logic     q_full;
  logic     q_pop;
  logic     q_empty;
  m3i_job_t q_wdata;
  m3i_job_t q_rdata;

  m3i_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_wdata  (q_wdata)
  );

  m3i_queue u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .wdata (q_wdata),
    .full  (q_full),
    .pop   (q_pop),
    .rdata (q_rdata),
    .empty (q_empty)
  );

  m3i_back #(.FRAC_BITS(FRAC_BITS)) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_empty   (q_empty),
    .q_pop     (q_pop),
    .q_rdata   (q_rdata),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule
